[src/gcanr_pkg.sv]
`timescale 1ns / 1ps

package gcanr_pkg;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned IN_KEY_W   = 8;

  typedef enum logic [1:0] {
    OP_ADD_NODE = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_FULL    = 2'd1,
    RES_MISSING = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_EDGE_RD,
    S_EDGE_WR,
    S_SEED,
    S_PICK,
    S_MERGE,
    S_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_word;
    logic    scan_start;
    logic    scan_step;
    logic    add_node;
    logic    edge_rd;
    logic    edge_wr;
    logic    seed;
    logic    pick;
    logic    merge;
    logic    load_res;
    logic    res_query;
    status_e res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic both_found;
    logic table_full;
    logic pend_empty;
  } sts_t;

endpackage

[src/gcanr_ctrl.sv]
`timescale 1ns / 1ps

module gcanr_ctrl
  import gcanr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic [1:0] s_op_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e  state_q, state_d;
  op_e     op_q, op_d;
  status_e res_q, res_d;
  logic    m_vld_q, m_vld_d;
  logic    accept;
  logic    out_free;

  assign accept   = (state_q == S_IDLE) && s_valid_i;
  assign out_free = !m_vld_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          op_d  = op_e'(s_op_i);
          res_d = RES_OK;
          unique case (op_e'(s_op_i))
            OP_ADD_NODE: state_d = S_ADD;
            OP_ADD_EDGE,
            OP_QUERY:    state_d = S_SCAN;
            default:     state_d = S_RESULT;
          endcase
        end
      end
      S_ADD: begin
        res_d   = sts_i.table_full ? RES_FULL : RES_OK;
        state_d = S_RESULT;
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          if (op_q == OP_QUERY) begin
            state_d = S_SEED;
          end else if (sts_i.both_found) begin
            state_d = S_EDGE_RD;
          end else begin
            res_d   = RES_MISSING;
            state_d = S_RESULT;
          end
        end
      end
      S_EDGE_RD: state_d = S_EDGE_WR;
      S_EDGE_WR: state_d = S_RESULT;
      S_SEED:    state_d = S_PICK;
      S_PICK:    state_d = sts_i.pend_empty ? S_RESULT : S_MERGE;
      S_MERGE:   state_d = S_PICK;
      S_RESULT: begin
        if (out_free) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = res_q;
    cmd_o.res_query  = (op_q == OP_QUERY);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_word  = accept;
        cmd_o.scan_start = accept;
      end
      S_ADD:     cmd_o.add_node = !sts_i.table_full;
      S_SCAN:    cmd_o.scan_step = 1'b1;
      S_EDGE_RD: cmd_o.edge_rd = 1'b1;
      S_EDGE_WR: cmd_o.edge_wr = 1'b1;
      S_SEED:    cmd_o.seed = 1'b1;
      S_PICK:    cmd_o.pick = !sts_i.pend_empty;
      S_MERGE:   cmd_o.merge = 1'b1;
      S_RESULT:  cmd_o.load_res = out_free;
      default:   cmd_o.load_res = 1'b0;
    endcase
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (m_ready_i) m_vld_d = 1'b0;
    if (cmd_o.load_res) m_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      res_q   <= RES_OK;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      res_q   <= res_d;
      m_vld_q <= m_vld_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_vld_q;

endmodule

[src/gcanr_dp.sv]
`timescale 1ns / 1ps

module gcanr_dp
  import gcanr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned KEY_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [IN_KEY_W-1:0]   first_key_i,
  input  logic [IN_KEY_W-1:0]   second_key_i,
  output sts_t                  sts_o,
  output logic [OUT_DATA_W-1:0] m_data_o
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  // slot store and adjacency rows
  logic [KEY_BITS-1:0]  key_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_vld_q;

  logic [KEY_BITS-1:0]  ka_q, kb_q;
  logic [31:0]          ka_ext, kb_ext;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        scan_idx_q;
  logic                 rd_vld_q;
  logic [IW-1:0]        rd_idx_q;
  logic [KEY_BITS-1:0]  key_rd_q;
  logic                 issue;
  logic                 src_fnd_q, dst_fnd_q;
  logic [IW-1:0]        src_q, dst_q;

  logic [MAX_NODES-1:0] active_q, reach_q, done_q;
  logic [MAX_NODES-1:0] pend, lowbit;
  logic [IW-1:0]        pick_idx;
  logic [IW-1:0]        adj_raddr;
  logic [MAX_NODES-1:0] adj_rd_q;
  logic                 adj_rvld_q;
  logic [MAX_NODES-1:0] row_eff;
  logic                 table_full;

  status_e              status_q;
  logic                 conn_q;

  assign ka_ext     = 32'(first_key_i);
  assign kb_ext     = 32'(second_key_i);
  assign table_full = (count_q == CW'(MAX_NODES));
  assign issue      = cmd_i.scan_step && (scan_idx_q != count_q);

  assign pend   = reach_q & ~done_q;
  assign lowbit = pend & (~pend + MAX_NODES'(1));

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (lowbit[i]) pick_idx = pick_idx | IW'(i);
    end
  end

  assign adj_raddr = cmd_i.edge_rd ? src_q : pick_idx;
  assign row_eff   = adj_rvld_q ? adj_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_node) key_mem[count_q[IW-1:0]] <= ka_q;
    if (issue) key_rd_q <= key_mem[scan_idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_wr) adj_mem[src_q] <= row_eff | (MAX_NODES'(1) << dst_q);
    if (cmd_i.edge_rd || cmd_i.pick) begin
      adj_rd_q   <= adj_mem[adj_raddr];
      adj_rvld_q <= row_vld_q[adj_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      ka_q <= ka_ext[KEY_BITS-1:0];
      kb_q <= kb_ext[KEY_BITS-1:0];
    end
    if (issue) rd_idx_q <= scan_idx_q[IW-1:0];
    if (rd_vld_q && !src_fnd_q && key_rd_q == ka_q) src_q <= rd_idx_q;
    if (rd_vld_q && !dst_fnd_q && key_rd_q == kb_q) dst_q <= rd_idx_q;
    if (cmd_i.load_res) begin
      status_q <= cmd_i.res_status;
      conn_q   <= cmd_i.res_query && ((active_q & ~reach_q) == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      row_vld_q  <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      src_fnd_q  <= 1'b0;
      dst_fnd_q  <= 1'b0;
      active_q   <= '0;
      reach_q    <= '0;
      done_q     <= '0;
    end else begin
      if (cmd_i.add_node) count_q <= count_q + CW'(1);
      if (cmd_i.edge_wr) row_vld_q[src_q] <= 1'b1;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        rd_vld_q   <= 1'b0;
        src_fnd_q  <= 1'b0;
        dst_fnd_q  <= 1'b0;
        active_q   <= '0;
      end else begin
        rd_vld_q <= issue;
        if (issue) scan_idx_q <= scan_idx_q + CW'(1);
        if (rd_vld_q) begin
          if (key_rd_q == ka_q) src_fnd_q <= 1'b1;
          if (key_rd_q == kb_q) dst_fnd_q <= 1'b1;
          active_q[rd_idx_q] <= (key_rd_q != ka_q);
        end
      end
      if (cmd_i.seed) begin
        reach_q <= active_q & (~active_q + MAX_NODES'(1));
        done_q  <= '0;
      end
      if (cmd_i.pick) done_q <= done_q | lowbit;
      if (cmd_i.merge) reach_q <= reach_q | (row_eff & active_q);
    end
  end

  assign sts_o.scan_done  = (scan_idx_q == count_q) && !rd_vld_q;
  assign sts_o.both_found = src_fnd_q && dst_fnd_q;
  assign sts_o.table_full = table_full;
  assign sts_o.pend_empty = (pend == '0);

  assign m_data_o = {{(OUT_DATA_W - 3){1'b0}}, conn_q, status_q};

endmodule

[src/graph_connectivity_after_node_removal.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Signals                     | Word
// s_axis   | in  | tvalid tready tdata tuser   | tdata: first_key, second_key; tuser: op
// m_axis   | out | tvalid tready tdata         | tdata: status, connected, zero pad
//
// One word in flight. Add node fills the next slot; add edge scans the slots, then
// updates the source row; a query scans, seeds, then walks the reached nodes.
// Slot scans read the key store one entry per cycle; the reach walk reads
// one adjacency row per reached node over its single read port.
// rst_ni clears node count, row valid bits, reach set and the handshake.
// m_axis stalls hold the result; a new word is taken while it waits.

module graph_connectivity_after_node_removal
  import gcanr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned KEY_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] first_key, [15:8] second_key
  input  logic [1:0]            s_axis_tuser,  // [1:0] op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [1:0] status, [2] connected
);

  cmd_t cmd;
  sts_t sts;

  gcanr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gcanr_dp #(
    .MAX_NODES (MAX_NODES),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .first_key_i  (s_axis_tdata[IN_KEY_W-1:0]),
    .second_key_i (s_axis_tdata[IN_DATA_W-1:IN_KEY_W]),
    .sts_o        (sts),
    .m_data_o     (m_axis_tdata)
  );

endmodule

[src/gcanr_chk.sv]
`timescale 1ns / 1ps

module gcanr_chk
  import gcanr_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [1:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 &&
                      m_axis_tdata[OUT_DATA_W-1:3] == '0)
    else $error("bad status code or pad bits");

  a_conn_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == RES_OK)
    else $error("connected flag set with error status");

endmodule

bind graph_connectivity_after_node_removal gcanr_chk u_gcanr_chk (.*);

[tb/tb_graph_connectivity_after_node_removal.sv]
`timescale 1ns / 1ps

module tb_graph_connectivity_after_node_removal;
  import gcanr_pkg::*;

  localparam int unsigned NODES     = 16;
  localparam int unsigned HOLD_CYC  = 300;
  localparam int unsigned DRAIN_CYC = 80;

  typedef struct {
    status_e status;
    logic    connected;
  } graph_reply_t;

  class connectivity_scoreboard;
    logic [7:0]   slot_key[NODES];
    int unsigned  slot_count;
    logic [15:0]  edge_row[NODES];
    graph_reply_t reply_q[$];
    int           errors;

    function new();
      slot_count = 0;
      errors = 0;
      foreach (edge_row[i]) begin
        edge_row[i] = '0;
        slot_key[i] = '0;
      end
    endfunction

    function int find_slot(logic [7:0] key);
      for (int i = 0; i < slot_count; i++) begin
        if (slot_key[i] == key) return i;
      end
      return NODES;
    endfunction

    function logic all_reached(logic [7:0] ignored);
      logic [15:0] active;
      logic [15:0] reach;
      logic [15:0] prev;
      active = '0;
      for (int i = 0; i < slot_count; i++) begin
        if (slot_key[i] != ignored) active[i] = 1'b1;
      end
      reach = active & (~active + 16'd1);
      do begin
        prev = reach;
        for (int i = 0; i < NODES; i++) begin
          if (reach[i]) reach |= edge_row[i] & active;
        end
      end while (reach != prev);
      return (active & ~reach) == '0;
    endfunction

    // accepted input word: update the graph and queue its reply
    function void note_word(op_e op, logic [7:0] key_a, logic [7:0] key_b);
      graph_reply_t r;
      int src;
      int dst;
      r.status = RES_OK;
      r.connected = 1'b0;
      case (op)
        OP_ADD_NODE: begin
          if (slot_count >= NODES) begin
            r.status = RES_FULL;
          end else begin
            slot_key[slot_count] = key_a;
            slot_count++;
          end
        end
        OP_ADD_EDGE: begin
          src = find_slot(key_a);
          dst = find_slot(key_b);
          if (src >= NODES || dst >= NODES) r.status = RES_MISSING;
          else edge_row[src][dst] = 1'b1;
        end
        OP_QUERY: r.connected = all_reached(key_a);
        default: ;
      endcase
      reply_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [OUT_DATA_W-1:0] word);
      graph_reply_t r;
      if (reply_q.size() == 0) begin
        report($sformatf("unexpected word %h", word));
      end else begin
        r = reply_q.pop_front();
        if (word[1:0] != r.status)
          report($sformatf("status %0d, want %0d", word[1:0], r.status));
        if (word[2] != r.connected)
          report($sformatf("connected %0b, want %0b", word[2], r.connected));
      end
    endtask

    function int pending_count();
      return reply_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  connectivity_scoreboard sb;
  bit no_idle;
  bit hold_req;

  graph_connectivity_after_node_removal #(
    .MAX_NODES(NODES),
    .KEY_BITS (8)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL graph_connectivity_after_node_removal");
    $finish;
  end

  // valid stays high across back-to-back words
  task automatic send_word(op_e op, logic [7:0] key_a, logic [7:0] key_b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {key_b, key_a};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, key_a, key_b);
  endtask

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && sb.slot_count > 0) return sb.slot_key[$urandom_range(0, sb.slot_count - 1)];
    if (r < 85) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      send_word(OP_ADD_NODE, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)));
    else if (r < 30) send_word(OP_ADD_EDGE, pick_key(), pick_key());
    else if (r < 95) send_word(OP_QUERY, pick_key(), 8'($urandom_range(0, 255)));
    else send_word(OP_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata);
    end
  end

  initial begin
    sb = new();
    no_idle = 1'b0;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_NONE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty graph, extreme keys, duplicates, missing endpoints
    send_word(OP_QUERY,    8'h00, 8'hff);
    send_word(OP_ADD_EDGE, 8'h00, 8'h00);
    send_word(OP_NONE,     8'hff, 8'hff);
    send_word(OP_ADD_NODE, 8'h00, 8'h00);
    send_word(OP_QUERY,    8'h00, 8'h00);
    send_word(OP_QUERY,    8'hff, 8'h00);
    send_word(OP_ADD_NODE, 8'hff, 8'hff);
    send_word(OP_ADD_NODE, 8'h00, 8'h00);
    send_word(OP_ADD_NODE, 8'h5a, 8'ha5);
    send_word(OP_QUERY,    8'h77, 8'h00);
    send_word(OP_ADD_EDGE, 8'h00, 8'hff);
    send_word(OP_ADD_EDGE, 8'h00, 8'hff);
    send_word(OP_ADD_EDGE, 8'hff, 8'h5a);
    send_word(OP_ADD_EDGE, 8'h5a, 8'h00);
    send_word(OP_QUERY,    8'h77, 8'h00);
    send_word(OP_QUERY,    8'h00, 8'h00);
    send_word(OP_ADD_EDGE, 8'hff, 8'h99);
    send_word(OP_ADD_EDGE, 8'h99, 8'h00);
    send_word(OP_QUERY,    8'hff, 8'h00);
    send_word(OP_ADD_EDGE, 8'hff, 8'h00);
    send_word(OP_QUERY,    8'h5a, 8'hff);
    send_word(OP_NONE,     8'h00, 8'h00);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      no_idle = (phase % 3 == 2);
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < 100; n++) send_random();
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS graph_connectivity_after_node_removal");
    end else begin
      $display("FAIL graph_connectivity_after_node_removal");
    end
    $finish;
  end

endmodule
